>>> src/wia_pkg.sv
// ---------------------------------------------------------------------------
// wia_pkg
// Shared types, operation codes and helpers for the wide integer ALU.
// ---------------------------------------------------------------------------
package wia_pkg;

  localparam int LimbW = 64;
  localparam int NLimb = 8;
  localparam int WideW = LimbW * NLimb;
  localparam int DefMaxLimbs = 8;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_SHL = 5'd8, OP_SHR = 5'd9,
    OP_NEG = 5'd10, OP_NOT = 5'd11, OP_EQ = 5'd12, OP_NE = 5'd13,
    OP_LT = 5'd14, OP_GT = 5'd15, OP_LE = 5'd16, OP_GE = 5'd17
  } op_t;

  typedef struct packed {
    logic [4:0]  operation;
    logic [9:0]  bit_count;
    logic        signed_compare;
    logic [63:0] a_limb;
    logic [63:0] b_limb;
    logic        last_limb;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_limb;
    logic        last_result;
    logic        error_code;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // store incoming limb
    logic start;     // set up the operation
    logic step;      // one iteration of divide or multiply
    logic finish;    // form final result
    logic shift_out; // move to next result limb
    logic clear;     // clear operand stores
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       iterative; // op needs the multi-cycle unit
    logic       iter_done;
    logic [3:0] nres;
  } dp_stat_t;

  // work width as log2 (3..9)
  function automatic logic [3:0] work_log2(input logic [9:0] bits);
    if (bits <= 10'd8) return 4'd3;
    else if (bits <= 10'd16) return 4'd4;
    else if (bits <= 10'd32) return 4'd5;
    else if (bits <= 10'd64) return 4'd6;
    else if (bits <= 10'd128) return 4'd7;
    else if (bits <= 10'd256) return 4'd8;
    return 4'd9;
  endfunction

endpackage

>>> src/wia_ctrl.sv
// ---------------------------------------------------------------------------
// wia_ctrl
// Sequencer: collects limbs, runs the iterative unit, sends result beats.
// ---------------------------------------------------------------------------
module wia_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  output logic              out_valid,
  output logic              out_last,
  input  logic              out_stall,
  output wia_pkg::dp_cmd_t  cmd,
  input  wia_pkg::dp_stat_t stat
);
  import wia_pkg::*;

  typedef enum logic [4:0] {
    S_COLLECT = 5'b00001,
    S_SETUP   = 5'b00010,
    S_ITER    = 5'b00100,
    S_FINISH  = 5'b01000,
    S_SEND    = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [3:0] sent;

  logic in_acc, out_acc;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (state != S_COLLECT);
  assign out_valid = (state == S_SEND);
  assign out_last  = (state == S_SEND) && (sent + 4'd1 == stat.nres);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_COLLECT: if (in_acc && in_last) state_next = S_SETUP;
      S_SETUP:   state_next = stat.iterative ? S_ITER : S_FINISH;
      S_ITER:    if (stat.iter_done) state_next = S_FINISH;
      S_FINISH:  state_next = S_SEND;
      S_SEND:    if (out_acc && out_last) state_next = S_COLLECT;
      default:   state_next = S_COLLECT;
    endcase
  end

  always_comb begin
    cmd.load      = in_acc;
    cmd.start     = (state == S_SETUP);
    cmd.step      = (state == S_ITER);
    cmd.finish    = (state == S_FINISH);
    cmd.shift_out = out_acc;
    cmd.clear     = out_acc && out_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
      sent  <= '0;
    end else begin
      state <= state_next;
      if (state == S_FINISH) sent <= '0;
      else if (out_acc) sent <= sent + 4'd1;
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_last_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sent < stat.nres) else $error("result count overrun");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |-> in_stall) else $error("input taken while sending");
`endif

endmodule

>>> src/wia_dp.sv
// ---------------------------------------------------------------------------
// wia_dp
// Operand stores, combinational ops, bit-serial divide and bit-serial multiply.
// ---------------------------------------------------------------------------
module wia_dp #(
  parameter int MAX_LIMBS = wia_pkg::DefMaxLimbs
) (
  input  logic               clk,
  input  logic               rst,
  input  wia_pkg::in_beat_t  in_beat,
  input  wia_pkg::dp_cmd_t   cmd,
  output wia_pkg::dp_stat_t  stat,
  output wia_pkg::out_beat_t out_beat
);
  import wia_pkg::*;

  localparam int CntW = $clog2(MAX_LIMBS + 1);

  logic [WideW-1:0] a_st, b_st;
  logic [CntW-1:0]  cnt;
  logic [2:0]       wr_idx;
  logic [4:0]       op;
  logic [9:0]       bc;
  logic             sgn;

  logic [WideW-1:0] a_w, b_w, mask_w, mask_b, res, acc, quo;
  logic [WideW:0]   rem;
  logic [9:0]       iter;
  logic [3:0]       lg;
  logic [9:0]       w_bits;
  logic [8:0]       top_idx;
  logic             err, is_div, is_mul;

  assign lg      = work_log2(bc);
  assign w_bits  = 10'd1 << lg;
  assign top_idx = 9'(w_bits - 10'd1);
  assign wr_idx  = 3'(cnt);
  always_comb begin
    mask_w = '1;
    mask_w = mask_w >> (10'(WideW) - w_bits);
    mask_b = (bc >= 10'(WideW)) ? '1 : ~({WideW{1'b1}} << bc);
  end
  assign a_w = a_st & mask_w;
  assign b_w = b_st & mask_w;
  assign is_div = (op == OP_DIV) || (op == OP_MOD);
  assign is_mul = (op == OP_MUL);

  assign stat.iterative = (is_div && (b_w != '0)) || is_mul;
  assign stat.iter_done = (iter == 10'd1);
  assign stat.nres = (lg <= 4'd6) ? 4'd1 : 4'(1 << (lg - 4'd6));

  // combinational operations, compares flip the top work bit when signed
  logic [WideW-1:0] ca, cb, simple;
  logic [WideW-1:0] topbit;
  logic             lt, eq, t;
  logic [7:0]       sh;
  always_comb begin
    topbit = '0;
    topbit[top_idx] = sgn;
    ca = a_w ^ topbit;
    cb = b_w ^ topbit;
    lt = ca < cb;
    eq = ca == cb;
    sh = b_w[7:0];
    case (op)
      OP_EQ: t = eq;
      OP_NE: t = !eq;
      OP_LT: t = lt;
      OP_GT: t = !lt && !eq;
      OP_LE: t = lt || eq;
      default: t = !lt;
    endcase
    case (op)
      OP_ADD: simple = a_w + b_w;
      OP_SUB: simple = a_w - b_w;
      OP_AND: simple = a_w & b_w;
      OP_OR:  simple = a_w | b_w;
      OP_XOR: simple = a_w ^ b_w;
      OP_SHL: simple = (10'(sh) >= w_bits) ? '0 : a_w << sh;
      OP_SHR: simple = (10'(sh) >= w_bits) ? '0 : a_w >> sh;
      OP_NEG: simple = '0 - a_w;
      OP_NOT: simple = ~a_w;
      default: simple = '0;
    endcase
  end

  // iterative step: both divide and multiply walk a from its top work bit
  logic [WideW:0]   rem_sh, rem_sub;
  logic [9:0]       bit_idx;
  assign bit_idx = iter - 10'd1;
  assign rem_sh  = {rem[WideW-1:0], a_w[bit_idx[8:0]]};
  assign rem_sub = rem_sh - {1'b0, b_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      op   <= '0;
      bc   <= '0;
      sgn  <= 1'b0;
      a_st <= '0;
      b_st <= '0;
      iter <= '0;
    end else begin
      if (cmd.load) begin
        if (cnt == '0) begin
          op  <= in_beat.operation;
          bc  <= in_beat.bit_count;
          sgn <= in_beat.signed_compare;
        end
        if (cnt < CntW'(MAX_LIMBS)) begin
          a_st[wr_idx*64 +: 64] <= in_beat.a_limb;
          b_st[wr_idx*64 +: 64] <= in_beat.b_limb;
          cnt <= cnt + 1'b1;
        end
      end
      if (cmd.start) iter <= w_bits;
      else if (cmd.step) iter <= iter - 10'd1;
      if (cmd.clear) begin
        a_st <= '0;
        b_st <= '0;
        cnt  <= '0;
      end
    end
  end

  // divide restores one bit per step; multiply shifts and adds b per bit of a
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= '0;
      quo <= '0;
      acc <= '0;
      err <= is_div && (b_w == '0);
    end else if (cmd.step) begin
      if (is_mul) begin
        acc <= (acc << 1) + (a_w[bit_idx[8:0]] ? b_w : '0);
      end else begin
        if (rem_sh[WideW] || !rem_sub[WideW]) begin
          rem <= rem_sub;
          quo[bit_idx[8:0]] <= 1'b1;
        end else begin
          rem <= rem_sh;
        end
      end
    end
    // divide by zero leaves quotient and remainder at zero
    if (cmd.finish) begin
      case (op)
        OP_DIV: res <= quo & mask_w & mask_b;
        OP_MOD: res <= rem[WideW-1:0] & mask_w & mask_b;
        OP_MUL: res <= acc & mask_w & mask_b;
        OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE: res <= WideW'(t);
        default: res <= simple & mask_w & mask_b;
      endcase
    end else if (cmd.shift_out) begin
      res <= res >> 64;
    end
  end

  assign out_beat.result_limb = res[63:0];
  assign out_beat.last_result = 1'b0;
  assign out_beat.error_code  = err;

endmodule

>>> src/wide_integer_alu_core.sv
// ---------------------------------------------------------------------------
// wide_integer_alu_core
// Multi-precision integer ALU, operands up to 512 bits in 64-bit limbs.
// ---------------------------------------------------------------------------
//  channel | direction | beat
//  in      | input     | one operand limb pair plus operation fields
//  out     | output    | one 64-bit result limb
//
//  divide, modulo and multiply run one bit per cycle over the work width W;
//  divide or modulo by zero and all other operations skip the iterative
//  unit and go from setup straight to finish.
//  results go out one limb per beat; input stalls from the last input beat
//  until the last result beat is taken.
//  rst is synchronous and clears the sequencer and the operand stores.
module wide_integer_alu_core #(
  parameter int MAX_LIMBS = wia_pkg::DefMaxLimbs
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  wia_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wia_pkg::out_beat_t out_data
);
  import wia_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_beat_t dp_out;
  logic      last;

  wia_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_last(in_data.last_limb),
    .in_stall(in_stall), .out_valid(out_valid), .out_last(last),
    .out_stall(out_stall), .cmd(cmd), .stat(stat)
  );

  wia_dp #(.MAX_LIMBS(MAX_LIMBS)) u_dp (
    .clk(clk), .rst(rst), .in_beat(in_data), .cmd(cmd), .stat(stat),
    .out_beat(dp_out)
  );

  always_comb begin
    out_data = dp_out;
    out_data.last_result = last;
  end

endmodule

>>> dv/wide_integer_alu_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// wide_integer_alu_core_tb
// Drives operand limbs for every operation and width, predicts the result
// limbs with a behavioral wide-integer model and checks each output beat.
// ---------------------------------------------------------------------------
module wide_integer_alu_core_tb;
  import wia_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam logic [4:0] OpBadLo = 5'd18;
  localparam logic [4:0] OpBadHi = 5'd31;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;

  out_beat_t result_fifo[$];
  int mismatch_count = 0;
  longint cycle_count = 0;
  int stall_mode = 0;

  // operand collection for prediction
  logic [511:0] acc_a, acc_b;
  int limb_idx = 0;
  logic [4:0] held_op;
  logic [9:0] held_bits;
  logic held_sgn;

  wide_integer_alu_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int width_of(logic [9:0] bits);
    return 1 << work_log2(bits);
  endfunction

  function automatic logic [511:0] low_mask(int bits);
    logic [511:0] m;
    m = '0;
    for (int i = 0; i < 512; i++) if (i < bits) m[i] = 1'b1;
    return m;
  endfunction

  // compute the result limbs of one finished operation
  task automatic predict_result(logic [4:0] op, logic [9:0] bits, logic sgn,
                                logic [511:0] a_in, logic [511:0] b_in);
    int w, nres, mbits, sh;
    logic [511:0] wm, a, b, r;
    logic err, t;
    out_beat_t beat;
    w = width_of(bits);
    nres = (w + 63) / 64;
    mbits = (bits > 512) ? 512 : bits;
    wm = low_mask(w);
    a = a_in & wm;
    b = b_in & wm;
    r = '0;
    err = 1'b0;
    case (op)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      OP_DIV, OP_MOD: begin
        if (b == '0) err = 1'b1;
        else r = (op == OP_DIV) ? a / b : a % b;
      end
      OP_AND: r = a & b;
      OP_OR: r = a | b;
      OP_XOR: r = a ^ b;
      OP_SHL: begin
        sh = b[7:0];
        r = (sh >= w) ? '0 : a << sh;
      end
      OP_SHR: begin
        sh = b[7:0];
        r = (sh >= w) ? '0 : a >> sh;
      end
      OP_NEG: r = '0 - a;
      OP_NOT: r = ~a;
      OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE: begin
        if (sgn) begin
          a[w-1] = ~a[w-1];
          b[w-1] = ~b[w-1];
        end
        case (op)
          OP_EQ: t = (a == b);
          OP_NE: t = (a != b);
          OP_LT: t = (a < b);
          OP_GT: t = (a > b);
          OP_LE: t = (a <= b);
          default: t = (a >= b);
        endcase
        r = '0;
        r[0] = t;
      end
      default: r = '0;
    endcase
    if (!(op inside {OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE}))
      r = r & wm & low_mask(mbits);
    for (int k = 0; k < nres; k++) begin
      beat.result_limb = r[k*64 +: 64];
      beat.last_result = (k == nres - 1);
      beat.error_code = err;
      result_fifo.push_back(beat);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  // send one beat and update the prediction when it is accepted
  task automatic send_limb(logic [4:0] op, logic [9:0] bits, logic sgn,
                           logic [63:0] a, logic [63:0] b, logic last);
    in_data <= '{operation: op, bit_count: bits, signed_compare: sgn,
                 a_limb: a, b_limb: b, last_limb: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (limb_idx == 0) begin
      held_op = op;
      held_bits = bits;
      held_sgn = sgn;
    end
    if (limb_idx < 8) begin
      acc_a[limb_idx*64 +: 64] = a;
      acc_b[limb_idx*64 +: 64] = b;
      limb_idx++;
    end
    if (last) begin
      predict_result(held_op, held_bits, held_sgn, acc_a, acc_b);
      acc_a = '0;
      acc_b = '0;
      limb_idx = 0;
    end
  endtask

  // optional gap after each beat; valid is lowered only when a gap is taken
  task automatic sender_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one whole operation with nlimbs beats; later beats carry random op fields
  task automatic send_operation(logic [4:0] op, logic [9:0] bits, logic sgn, int nlimbs,
                                logic [63:0] a0, logic [63:0] b0, bit rand_rest);
    for (int i = 0; i < nlimbs; i++) begin
      send_limb((i == 0) ? op : 5'($urandom), (i == 0) ? bits : 10'($urandom),
                (i == 0) ? sgn : 1'($urandom),
                (i == 0) ? a0 : (rand_rest ? rand64() : 64'd0),
                (i == 0) ? b0 : (rand_rest ? rand64() : 64'd0), i == nlimbs - 1);
      sender_gap();
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (result_fifo.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // check each accepted result beat
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (result_fifo.size() == 0) begin
        report_mismatch("unexpected beat", out_data.result_limb, 64'd0);
      end else begin
        want = result_fifo.pop_front();
        if (out_data.result_limb !== want.result_limb)
          report_mismatch("result_limb", out_data.result_limb, want.result_limb);
        if (out_data.last_result !== want.last_result)
          report_mismatch("last_result", 64'(out_data.last_result), 64'(want.last_result));
        if (out_data.error_code !== want.error_code)
          report_mismatch("error_code", 64'(out_data.error_code), 64'(want.error_code));
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ((cycle_count % 11) < 6);
    endcase
  end

  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    send_operation(OP_ADD, 10'd512, 1'b0, 8, ones, ones, 1'b1);
    send_operation(OP_SUB, 10'd0, 1'b0, 1, 64'd5, 64'd9, 1'b0);
    send_operation(OP_MUL, 10'd1023, 1'b0, 9, ones, ones, 1'b1);
    send_operation(OP_DIV, 10'd64, 1'b0, 1, ones, 64'd0, 1'b0);
    send_operation(OP_MOD, 10'd512, 1'b0, 8, ones, 64'd0, 1'b0);
    send_operation(OP_DIV, 10'd512, 1'b0, 8, rand64(), rand64(), 1'b1);
    send_operation(OP_MOD, 10'd128, 1'b0, 2, ones, 64'h8000_0000_0000_0001, 1'b1);
    send_operation(OP_AND, 10'd13, 1'b0, 1, ones, 64'hF0F0, 1'b0);
    send_operation(OP_OR, 10'd200, 1'b0, 4, 64'd0, ones, 1'b1);
    send_operation(OP_XOR, 10'd1, 1'b0, 1, ones, 64'd0, 1'b0);
    send_operation(OP_SHL, 10'd512, 1'b0, 8, ones, 64'd511, 1'b1);
    send_operation(OP_SHL, 10'd32, 1'b0, 1, ones, 64'd32, 1'b0);
    send_operation(OP_SHR, 10'd256, 1'b0, 4, ones, 64'd255, 1'b1);
    send_operation(OP_NEG, 10'd100, 1'b0, 2, 64'd1, 64'd0, 1'b0);
    send_operation(OP_NOT, 10'd0, 1'b0, 1, 64'd0, 64'd0, 1'b0);
    send_operation(OP_EQ, 10'd0, 1'b0, 1, 64'd0, 64'd0, 1'b0);
    send_operation(OP_NE, 10'd8, 1'b1, 1, 64'h80, 64'h7F, 1'b0);
    send_operation(OP_LT, 10'd8, 1'b1, 1, 64'h80, 64'h7F, 1'b0);
    send_operation(OP_GT, 10'd512, 1'b1, 8, ones, 64'd1, 1'b1);
    send_operation(OP_LE, 10'd16, 1'b0, 1, 64'hFFFF, 64'hFFFF, 1'b0);
    send_operation(OP_GE, 10'd64, 1'b1, 1, ones, 64'd0, 1'b0);
    send_operation(OpBadHi, 10'd300, 1'b0, 5, ones, ones, 1'b1);
    send_operation(OpBadLo, 10'd9, 1'b0, 1, ones, ones, 1'b0);
  endtask

  // random operations, mostly well-formed and mostly small widths
  task automatic test_random(int count);
    logic [9:0] bits;
    logic [4:0] op;
    int nl;
    logic [63:0] bv;
    for (int n = 0; n < count; ) begin
      case ($urandom_range(0, 9))
        0: bits = 10'($urandom);
        1, 2: bits = 10'($urandom_range(257, 512));
        default: bits = 10'($urandom_range(0, 128));
      endcase
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(OpBadLo, OpBadHi))
                                        : 5'($urandom_range(OP_ADD, OP_GE));
      nl = $urandom_range(1, 10);
      if (op inside {OP_DIV, OP_MOD} && bits > 10'd256) nl = $urandom_range(1, 3);
      bv = ($urandom_range(0, 9) == 0) ? 64'd0 : rand64();
      if (op inside {OP_SHL, OP_SHR} && $urandom_range(0, 1)) bv = 64'($urandom_range(0, 600));
      send_operation(op, bits, 1'($urandom), nl, rand64(), bv, 1'b1);
      n += nl;
      if (n > count / 2 && stall_mode == 0) stall_mode = 1;
      if (n > 3 * count / 4) stall_mode = 2;
    end
  endtask

  initial begin
    acc_a = '0;
    acc_b = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    // hold off until every result has drained
    wait_drained();
    stall_mode = 1;
    test_random(382);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/wia_pkg.sv
src/wia_ctrl.sv
src/wia_dp.sv
src/wide_integer_alu_core.sv
dv/wide_integer_alu_core_tb.sv
